FILE: hw/rtl/key_event_linked_queue_assert.svh
// Assertion macros shared by the key event queue RTL.
// Included by the controller and the datapath; empty under synthesis.
`ifndef KEY_EVENT_LINKED_QUEUE_ASSERT_SVH
`define KEY_EVENT_LINKED_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk, off during reset
`define KELQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kelq assertion failed");
// next-cycle implication on clk, off during reset
`define KELQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kelq assertion failed");
`else
`define KELQ_ASSERT_IMP(lbl, ante, cons)
`define KELQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/kelq_pkg.sv
// Shared constants, codes and command/status types of the key event queue.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package kelq_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int KEY_W      = 8;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int PTR_W      = IDX_W + 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int TIME_W     = 32;
  localparam int GAP_W      = 16;
  localparam int POS_W      = 4;
  localparam int OP_W       = 4;
  localparam int KIND_W     = 2;
  localparam int ST_W       = 2;

  localparam logic [PTR_W-1:0] PTR_NIL = {PTR_W{1'b1}};

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 4'd2;
  localparam logic [OP_W-1:0] OP_PAST  = 4'd3;
  localparam logic [OP_W-1:0] OP_DELN  = 4'd4;
  localparam logic [OP_W-1:0] OP_DELM  = 4'd5;
  localparam logic [OP_W-1:0] OP_COUNT = 4'd6;
  localparam logic [OP_W-1:0] OP_PEEK  = 4'd7;
  localparam logic [OP_W-1:0] OP_FIND  = 4'd8;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd3;

  // event kind filter codes
  localparam logic [KIND_W-1:0] KIND_ANY     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  // walk start selection
  localparam logic [1:0] WS_START = 2'd0;
  localparam logic [1:0] WS_HEAD  = 2'd1;
  localparam logic [1:0] WS_READ  = 2'd2;
  localparam logic [1:0] WS_TAIL  = 2'd3;

  typedef struct packed {
    logic            capture;
    logic            clear;
    logic            push;
    logic            walk_init;
    logic [1:0]      walk_src;
    logic            walk_next;
    logic            cnt_add;
    logic            read_adv;
    logic            del_step;
    logic            del_apply;
    logic            dm_prep;
    logic            dm_set;
    logic            hn_save;
    logic            out_load;
    logic [ST_W-1:0] out_status;
    logic [OP_W-1:0] out_op;
  } cmd_t;

  typedef struct packed {
    logic p_ok;
    logic p_is_end;
    logic link_ok;
    logic link_is_end;
    logic kind_hit;
    logic key_hit;
    logic idx_max;
    logic idx_zero;
    logic cnt_eq_n;
    logic del_hit;
    logic free_found;
    logic tail_ok;
    logic gap_wait;
  } sts_t;

  function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
    return p < PTR_W'(POOL_DEPTH);
  endfunction

endpackage

FILE: hw/rtl/kelq_datapath.sv
// Datapath of the key event queue: slot pool, list pointers, walk registers
// and result register. Depends on kelq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "key_event_linked_queue_assert.svh"
module kelq_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kelq_pkg::cmd_t              cmd,
  output kelq_pkg::sts_t              sts,
  input  logic                        in_region,
  input  logic [kelq_pkg::KEY_W-1:0]  in_key_index,
  input  logic                        in_key_pressed,
  input  logic [kelq_pkg::TIME_W-1:0] in_time_ms,
  input  logic [kelq_pkg::GAP_W-1:0]  in_gap_ms,
  input  logic [kelq_pkg::POS_W-1:0]  in_position,
  input  logic [kelq_pkg::KIND_W-1:0] in_event_kind,
  output logic [kelq_pkg::ST_W-1:0]   out_status,
  output logic [kelq_pkg::CNT_W-1:0]  out_entry_count,
  output logic [kelq_pkg::POS_W-1:0]  out_found_position,
  output logic [kelq_pkg::KEY_W-1:0]  out_key_index,
  output logic                        out_pressed,
  output logic [kelq_pkg::TIME_W-1:0] out_time_ms
);
  import kelq_pkg::*;

  // slot pool, contents undefined until pushed
  logic [KEY_W-1:0]      slot_key_r  [POOL_DEPTH];
  logic                  slot_pr_r   [POOL_DEPTH];
  logic [TIME_W-1:0]     slot_time_r [POOL_DEPTH];
  logic [PTR_W-1:0]      slot_link_r [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] busy_r, busy_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt, read_r, read_nxt, tail_r, tail_nxt;

  // captured operands
  logic                  reg_r;
  logic [KEY_W-1:0]      key_r;
  logic                  pr_r;
  logic [TIME_W-1:0]     now_r;
  logic [GAP_W-1:0]      gap_r;
  logic [POS_W-1:0]      n_r;
  logic [KIND_W-1:0]     kind_r;

  // walk state
  logic [PTR_W-1:0]      p_r, p1_r, p2_r;
  logic [CNT_W-1:0]      cnt_r, idx_r, hn_r;
  logic                  started_r;

  // result register
  logic [ST_W-1:0]       ost_r;
  logic [CNT_W-1:0]      ocnt_r;
  logic [POS_W-1:0]      opos_r;
  logic [KEY_W-1:0]      okey_r;
  logic                  opr_r;
  logic [TIME_W-1:0]     otime_r;

  logic [IDX_W-1:0]      rd_idx, free_idx;
  logic                  free_found;
  logic [KEY_W-1:0]      rd_key;
  logic                  rd_pr;
  logic [TIME_W-1:0]     rd_time;
  logic [PTR_W-1:0]      rd_link, start_p, end_p, src_p;
  logic                  kind_hit, p_is_start, started_eff, res_ok;
  logic [CNT_W-1:0]      cnt_eff;
  logic [TIME_W-1:0]     age;

  // read the slot under the walk pointer
  assign rd_idx  = p_r[IDX_W-1:0];
  assign rd_key  = slot_key_r[rd_idx];
  assign rd_pr   = slot_pr_r[rd_idx];
  assign rd_time = slot_time_r[rd_idx];
  assign rd_link = slot_link_r[rd_idx];

  assign start_p = reg_r ? read_r : head_r;
  assign end_p   = reg_r ? PTR_NIL : read_r;

  always_comb begin
    case (kind_r)
      KIND_ANY:     kind_hit = 1'b1;
      KIND_PRESS:   kind_hit = rd_pr;
      KIND_RELEASE: kind_hit = !rd_pr;
      default:      kind_hit = 1'b0;
    endcase
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign p_is_start  = (p_r == start_p);
  assign started_eff = started_r || p_is_start;
  assign cnt_eff     = p_is_start ? '0 : cnt_r;
  assign age         = now_r - rd_time;

  always_comb begin
    sts.p_ok        = ptr_ok(p_r);
    sts.p_is_end    = (p_r == end_p);
    sts.link_ok     = ptr_ok(rd_link);
    sts.link_is_end = (rd_link == end_p);
    sts.kind_hit    = kind_hit;
    sts.key_hit     = (rd_key == key_r) && (rd_pr == pr_r);
    sts.idx_max     = (idx_r == CNT_W'(POOL_DEPTH));
    sts.idx_zero    = (idx_r == '0);
    sts.cnt_eq_n    = (cnt_r == CNT_W'(n_r));
    sts.del_hit     = started_eff && (cnt_eff == CNT_W'(n_r));
    sts.free_found  = free_found;
    sts.tail_ok     = ptr_ok(tail_r);
    sts.gap_wait    = (gap_r != '0) && (age < TIME_W'(gap_r));
  end

  // pointer and occupancy updates
  always_comb begin
    busy_nxt = busy_r;
    head_nxt = head_r;
    read_nxt = read_r;
    tail_nxt = tail_r;
    if (cmd.clear) begin
      busy_nxt = '0;
      head_nxt = PTR_NIL;
      read_nxt = PTR_NIL;
      tail_nxt = PTR_NIL;
    end
    if (cmd.push && free_found) begin
      busy_nxt[free_idx] = 1'b1;
      tail_nxt = PTR_W'(free_idx);
      if (!ptr_ok(head_r)) head_nxt = PTR_W'(free_idx);
      if (!ptr_ok(read_r)) read_nxt = PTR_W'(free_idx);
    end
    if (cmd.read_adv) read_nxt = rd_link;
    if (cmd.del_apply) begin
      if (n_r == '0) begin
        if (head_r == read_r) head_nxt = p_r;
        if (reg_r) read_nxt = p_r;
        else head_nxt = p_r;
      end
      if (tail_r == p1_r) tail_nxt = p2_r;
      busy_nxt[p1_r[IDX_W-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      head_r <= PTR_NIL;
      read_r <= PTR_NIL;
      tail_r <= PTR_NIL;
    end else begin
      busy_r <= busy_nxt;
      head_r <= head_nxt;
      read_r <= read_nxt;
      tail_r <= tail_nxt;
    end
  end

  // write slot contents and relink
  always_ff @(posedge clk) begin
    if (cmd.push && free_found) begin
      slot_key_r[free_idx]  <= key_r;
      slot_pr_r[free_idx]   <= pr_r;
      slot_time_r[free_idx] <= now_r;
      slot_link_r[free_idx] <= PTR_NIL;
      if (ptr_ok(tail_r)) slot_link_r[tail_r[IDX_W-1:0]] <= PTR_W'(free_idx);
    end
    if (cmd.del_apply && ptr_ok(p2_r)) slot_link_r[p2_r[IDX_W-1:0]] <= p_r;
  end

  // hold operands of the current transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      reg_r  <= in_region;
      key_r  <= in_key_index;
      pr_r   <= in_key_pressed;
      now_r  <= in_time_ms;
      gap_r  <= in_gap_ms;
      n_r    <= in_position;
      kind_r <= in_event_kind;
    end
    if (cmd.dm_prep) begin
      reg_r  <= 1'b0;
      kind_r <= KIND_ANY;
    end
    if (cmd.dm_set) begin
      kind_r <= KIND_ANY;
      if (idx_r < hn_r) begin
        reg_r <= 1'b0;
        n_r   <= idx_r[POS_W-1:0];
      end else begin
        reg_r <= 1'b1;
        n_r   <= POS_W'(idx_r - hn_r);
      end
    end
  end

  always_comb begin
    case (cmd.walk_src)
      WS_START: src_p = start_p;
      WS_HEAD:  src_p = head_r;
      WS_READ:  src_p = read_r;
      default:  src_p = tail_r;
    endcase
  end

  // advance the walk registers
  always_ff @(posedge clk) begin
    if (cmd.hn_save) hn_r <= cnt_r;
    if (cmd.walk_init) begin
      p_r       <= src_p;
      p1_r      <= PTR_NIL;
      p2_r      <= PTR_NIL;
      cnt_r     <= '0;
      idx_r     <= '0;
      started_r <= 1'b0;
    end else if (cmd.del_step) begin
      started_r <= started_eff;
      p2_r      <= p1_r;
      p1_r      <= p_r;
      p_r       <= rd_link;
      idx_r     <= idx_r + 1'b1;
      if (started_eff) cnt_r <= cnt_eff + CNT_W'(kind_hit);
    end else begin
      if (cmd.walk_next) begin
        p_r   <= rd_link;
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.cnt_add) cnt_r <= cnt_r + 1'b1;
    end
  end

  // load the result register
  assign res_ok = (cmd.out_status == ST_OK);
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ost_r   <= cmd.out_status;
      ocnt_r  <= (res_ok && cmd.out_op == OP_COUNT) ? cnt_r : '0;
      opos_r  <= (res_ok && cmd.out_op == OP_FIND) ? idx_r[POS_W-1:0] : '0;
      okey_r  <= (res_ok && cmd.out_op == OP_PEEK) ? rd_key : '0;
      opr_r   <= (res_ok && cmd.out_op == OP_PEEK) ? rd_pr : 1'b0;
      otime_r <= (res_ok && cmd.out_op == OP_PEEK) ? rd_time : '0;
    end
  end

  assign out_status         = ost_r;
  assign out_entry_count    = ocnt_r;
  assign out_found_position = opos_r;
  assign out_key_index      = okey_r;
  assign out_pressed        = opr_r;
  assign out_time_ms        = otime_r;

  `KELQ_ASSERT_IMP(a_idx_bound, cmd.walk_next || cmd.del_step, idx_r < CNT_W'(POOL_DEPTH))
  `KELQ_ASSERT_IMP(a_push_free, cmd.push && free_found, !busy_r[free_idx])
  `KELQ_ASSERT_IMP(a_del_busy, cmd.del_apply, ptr_ok(p1_r) && busy_r[p1_r[IDX_W-1:0]])

endmodule

FILE: hw/rtl/kelq_ctrl.sv
// Controller of the key event queue: sequences each operation over the
// datapath walk and owns the result handshake. Depends on kelq_pkg.
`timescale 1ns / 1ps
`include "key_event_linked_queue_assert.svh"
module kelq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [kelq_pkg::OP_W-1:0] in_operation,
  output logic                      out_valid,
  input  logic                      out_stall,
  output kelq_pkg::cmd_t            cmd,
  input  kelq_pkg::sts_t            sts
);
  import kelq_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_STEP    = 5'd2;
  localparam logic [4:0] S_PAST    = 5'd3;
  localparam logic [4:0] S_DEL     = 5'd4;
  localparam logic [4:0] S_DEL_APP = 5'd5;
  localparam logic [4:0] S_DM_INIT = 5'd6;
  localparam logic [4:0] S_DM_HN   = 5'd7;
  localparam logic [4:0] S_DM_FIND = 5'd8;
  localparam logic [4:0] S_DM_DINI = 5'd9;
  localparam logic [4:0] S_CNT     = 5'd10;
  localparam logic [4:0] S_PK0     = 5'd11;
  localparam logic [4:0] S_PK_GAP  = 5'd12;
  localparam logic [4:0] S_PK      = 5'd13;
  localparam logic [4:0] S_FIND    = 5'd14;
  localparam logic [4:0] S_DONE    = 5'd15;

  logic [4:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  logic [ST_W-1:0] st_r, st_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd.out_status = st_r;
    cmd.out_op     = op_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        st_nxt    = ST_OK;
        case (op_r)
          OP_CLEAR: cmd.clear = 1'b1;
          OP_PUSH: begin
            if (sts.free_found) cmd.push = 1'b1;
            else st_nxt = ST_FULL;
          end
          OP_STEP: begin
            cmd.walk_init = 1'b1;
            cmd.walk_src  = WS_READ;
            state_nxt     = S_STEP;
          end
          OP_PAST: begin
            cmd.walk_init = 1'b1;
            cmd.walk_src  = WS_READ;
            state_nxt     = S_PAST;
          end
          OP_DELN: begin
            cmd.walk_init = 1'b1;
            cmd.walk_src  = WS_HEAD;
            state_nxt     = S_DEL;
          end
          OP_DELM: begin
            cmd.dm_prep = 1'b1;
            state_nxt   = S_DM_INIT;
          end
          OP_COUNT: begin
            cmd.walk_init = 1'b1;
            cmd.walk_src  = WS_START;
            state_nxt     = S_CNT;
          end
          OP_PEEK: begin
            cmd.walk_init = 1'b1;
            cmd.walk_src  = WS_START;
            state_nxt     = S_PK0;
          end
          OP_FIND: begin
            cmd.walk_init = 1'b1;
            cmd.walk_src  = WS_START;
            state_nxt     = S_FIND;
          end
          default: st_nxt = ST_OK;
        endcase
      end
      S_STEP: begin
        state_nxt = S_DONE;
        if (!sts.p_ok) st_nxt = ST_NONE;
        else begin
          cmd.read_adv = 1'b1;
          st_nxt       = ST_OK;
        end
      end
      // move read past the first matching event
      S_PAST: begin
        if (sts.idx_max || !sts.p_ok) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else if (sts.key_hit) begin
          cmd.read_adv = 1'b1;
          st_nxt       = ST_OK;
          state_nxt    = S_DONE;
        end else cmd.walk_next = 1'b1;
      end
      // walk from head to the entry to unlink
      S_DEL: begin
        if (!sts.p_ok) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else if (sts.idx_max) begin
          st_nxt    = ST_BAD;
          state_nxt = S_DONE;
        end else if (sts.p_is_end) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else begin
          cmd.del_step = 1'b1;
          if (sts.del_hit) state_nxt = S_DEL_APP;
        end
      end
      S_DEL_APP: begin
        cmd.del_apply = 1'b1;
        st_nxt        = ST_OK;
        state_nxt     = S_DONE;
      end
      S_DM_INIT: begin
        cmd.walk_init = 1'b1;
        cmd.walk_src  = WS_START;
        state_nxt     = S_CNT;
      end
      // count the region; delete match reuses it for the hold length
      S_CNT: begin
        if (sts.idx_zero && (sts.p_is_end || !sts.p_ok)) begin
          st_nxt    = ST_OK;
          state_nxt = (op_r == OP_DELM) ? S_DM_HN : S_DONE;
        end else if (sts.idx_max) begin
          st_nxt    = ST_BAD;
          state_nxt = S_DONE;
        end else begin
          cmd.cnt_add = sts.kind_hit;
          if (sts.link_is_end) begin
            st_nxt    = ST_OK;
            state_nxt = (op_r == OP_DELM) ? S_DM_HN : S_DONE;
          end else if (!sts.link_ok) begin
            st_nxt    = ST_BAD;
            state_nxt = S_DONE;
          end else cmd.walk_next = 1'b1;
        end
      end
      S_DM_HN: begin
        cmd.hn_save   = 1'b1;
        cmd.walk_init = 1'b1;
        cmd.walk_src  = WS_HEAD;
        state_nxt     = S_DM_FIND;
      end
      S_DM_FIND: begin
        if (sts.idx_max || !sts.p_ok) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else if (sts.key_hit) begin
          cmd.dm_set = 1'b1;
          state_nxt  = S_DM_DINI;
        end else cmd.walk_next = 1'b1;
      end
      S_DM_DINI: begin
        cmd.walk_init = 1'b1;
        cmd.walk_src  = WS_HEAD;
        state_nxt     = S_DEL;
      end
      S_PK0: begin
        if (sts.p_is_end || !sts.p_ok || !sts.tail_ok) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else begin
          cmd.walk_init = 1'b1;
          cmd.walk_src  = WS_TAIL;
          state_nxt     = S_PK_GAP;
        end
      end
      // hold back while the newest event is too recent
      S_PK_GAP: begin
        if (sts.gap_wait) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else begin
          cmd.walk_init = 1'b1;
          cmd.walk_src  = WS_START;
          state_nxt     = S_PK;
        end
      end
      S_PK: begin
        if (sts.idx_max) begin
          st_nxt    = ST_BAD;
          state_nxt = S_DONE;
        end else if (sts.kind_hit && sts.cnt_eq_n) begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          cmd.cnt_add = sts.kind_hit;
          if (sts.link_is_end) begin
            st_nxt    = ST_NONE;
            state_nxt = S_DONE;
          end else if (!sts.link_ok) begin
            st_nxt    = ST_BAD;
            state_nxt = S_DONE;
          end else cmd.walk_next = 1'b1;
        end
      end
      S_FIND: begin
        if (sts.p_is_end) begin
          st_nxt    = ST_NONE;
          state_nxt = S_DONE;
        end else if (sts.idx_max || !sts.p_ok) begin
          st_nxt    = ST_BAD;
          state_nxt = S_DONE;
        end else if (sts.key_hit) begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else cmd.walk_next = 1'b1;
      end
      // hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) op_r <= in_operation;
    st_r <= st_nxt;
  end

  `KELQ_ASSERT_NXT(a_accept_busy, accept, state_r == S_DECODE)
  `KELQ_ASSERT_IMP(a_rise_from_done, $rose(out_valid_r), $past(state_r == S_DONE))
  `KELQ_ASSERT_NXT(a_done_waits, state_r == S_DONE && out_valid_r && out_stall, state_r == S_DONE)

endmodule

FILE: hw/rtl/key_event_linked_queue.sv
// Key event queue: 16-slot linked pool with head, read and tail pointers.
// Clear, push and unknown operations finish in the decode state; the other operations
// walk the linked slots, and delete match counts, searches, then unlinks.
// One operation at a time; the next transfer is taken the cycle after the result
// register loads. Reset: synchronous; pool empty, pointers null.
`timescale 1ns / 1ps
module key_event_linked_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kelq_pkg::OP_W-1:0]   in_operation,
  input  logic                        in_region,
  input  logic [kelq_pkg::KEY_W-1:0]  in_key_index,
  input  logic                        in_key_pressed,
  input  logic [kelq_pkg::TIME_W-1:0] in_time_ms,
  input  logic [kelq_pkg::GAP_W-1:0]  in_gap_ms,
  input  logic [kelq_pkg::POS_W-1:0]  in_position,
  input  logic [kelq_pkg::KIND_W-1:0] in_event_kind,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kelq_pkg::ST_W-1:0]   out_status,
  output logic [kelq_pkg::CNT_W-1:0]  out_entry_count,
  output logic [kelq_pkg::POS_W-1:0]  out_found_position,
  output logic [kelq_pkg::KEY_W-1:0]  out_key_index,
  output logic                        out_pressed,
  output logic [kelq_pkg::TIME_W-1:0] out_time_ms
);
  import kelq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kelq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  kelq_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_region          (in_region),
    .in_key_index       (in_key_index),
    .in_key_pressed     (in_key_pressed),
    .in_time_ms         (in_time_ms),
    .in_gap_ms          (in_gap_ms),
    .in_position        (in_position),
    .in_event_kind      (in_event_kind),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_found_position (out_found_position),
    .out_key_index      (out_key_index),
    .out_pressed        (out_pressed),
    .out_time_ms        (out_time_ms)
  );

endmodule
